// File: rtl/core/bps_pkg.sv
`default_nettype none
package bps_pkg;

  localparam int PATTERN_DEPTH_DEF = 64;
  localparam int IDX_W = 6;
  localparam int IDX_COUNT = 1 << IDX_W;
  localparam int BYTE_W = 8;
  localparam int TPU_W = 7;
  localparam int COUNT_W = 15;
  localparam int REP_W = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [BYTE_W-1:0] END_MARK = 8'hF0;
  localparam logic [TPU_W-1:0] TPU_RESET = 7'd10;
  localparam logic REG_TPU = 1'b0;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_ON    = 3'd2,
    PH_OFF   = 3'd3,
    PH_STOP  = 3'd4
  } phase_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   index;
    logic [BYTE_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic   drive;
    phase_t phase;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/core/bps_cfg_regs.sv
`default_nettype none
module bps_cfg_regs
  import bps_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [TPU_W-1:0]      ticks_per_unit
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_unit <= TPU_RESET;
    end else if (wr_en && (paddr[2] == REG_TPU)) begin
      ticks_per_unit <= pwdata[TPU_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TPU) begin
      prdata = {{(CFG_DATA_W-TPU_W){1'b0}}, ticks_per_unit};
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/bps_pattern_store.sv
`default_nettype none
module bps_pattern_store
  import bps_pkg::*;
#(
  parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF,
  localparam int PW = $clog2(PATTERN_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_index,
  input  wire logic [BYTE_W-1:0] wr_data,
  input  wire logic [PW-1:0]     rd_addr,
  output logic      [BYTE_W-1:0] rd_byte
);

  logic [BYTE_W-1:0] mem [PATTERN_DEPTH];
  logic [PW-1:0]     idx_map [IDX_COUNT];
  logic [PW-1:0]     wr_addr;
  logic [BYTE_W-1:0] rd_q;
  logic [BYTE_W-1:0] wr_data_q;
  logic              hit_q;

  // The load index wraps at the store depth.
  for (genvar g = 0; g < IDX_COUNT; g++) begin : g_idx_map
    assign idx_map[g] = PW'(g % PATTERN_DEPTH);
  end

  assign wr_addr = idx_map[wr_index];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // A write to the entry being read this cycle is forwarded.
  always_ff @(posedge clk) begin
    hit_q     <= wr_en && (wr_addr == rd_addr);
    wr_data_q <= wr_data;
  end

  assign rd_byte = hit_q ? wr_data_q : rd_q;

endmodule
`default_nettype wire

// File: rtl/core/bps_phase_ctrl.sv
`default_nettype none
module bps_phase_ctrl
  import bps_pkg::*;
#(
  parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF,
  localparam int PW = $clog2(PATTERN_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire item_t             item,
  input  wire logic [BYTE_W-1:0] cur_byte,
  input  wire logic [TPU_W-1:0]  ticks_per_unit,
  output logic      [PW-1:0]     rd_addr,
  output status_t                status
);

  phase_t             phase;
  phase_t             phase_next;
  logic [PW-1:0]      position;
  logic [PW-1:0]      position_next;
  logic [REP_W-1:0]   repeats_done;
  logic [REP_W-1:0]   repeats_done_next;
  logic [COUNT_W-1:0] countdown;
  logic [COUNT_W-1:0] countdown_next;
  logic               drive;
  logic               drive_next;

  logic               is_tick;
  logic               step;
  logic               repeat_ok;
  logic [COUNT_W-1:0] prod;
  logic [COUNT_W-1:0] dur;
  logic [PW-1:0]      pos_inc;

  assign is_tick   = accept && (item.op == OP_TICK) && (phase != PH_IDLE);
  assign step      = is_tick && (countdown <= COUNT_W'(1));
  assign repeat_ok = repeats_done < cur_byte[REP_W-1:0];
  assign prod      = {{(COUNT_W-BYTE_W){1'b0}}, cur_byte}
                   * {{(COUNT_W-TPU_W){1'b0}}, ticks_per_unit};
  assign dur       = (prod == '0) ? COUNT_W'(1) : prod;
  assign pos_inc   = (position == PW'(PATTERN_DEPTH - 1)) ? '0 : position + PW'(1);

  always_comb begin
    phase_next = phase;
    if (accept) begin
      case (item.op)
        OP_TICK: begin
          if (step) begin
            case (phase)
              PH_START: phase_next = PH_ON;
              PH_ON:    phase_next = PH_OFF;
              PH_OFF: begin
                if (cur_byte < END_MARK) begin
                  phase_next = PH_ON;
                end else if (cur_byte == END_MARK) begin
                  phase_next = PH_STOP;
                end else if (repeat_ok) begin
                  phase_next = PH_START;
                end else begin
                  phase_next = PH_STOP;
                end
              end
              default:  phase_next = PH_IDLE;
            endcase
          end
        end
        OP_START: phase_next = PH_START;
        OP_STOP: begin
          if (phase != PH_IDLE) begin
            phase_next = PH_STOP;
          end
        end
        default: phase_next = phase;
      endcase
    end
  end

  always_comb begin
    position_next     = position;
    repeats_done_next = repeats_done;
    countdown_next    = countdown;
    drive_next        = drive;
    if (accept && (item.op == OP_START)) begin
      position_next     = '0;
      repeats_done_next = '0;
    end else if (is_tick && !step) begin
      countdown_next = countdown - COUNT_W'(1);
    end else if (step) begin
      countdown_next = COUNT_W'(1);
      case (phase)
        PH_START: begin
          drive_next     = 1'b1;
          position_next  = pos_inc;
          countdown_next = dur;
        end
        PH_ON: begin
          drive_next     = 1'b0;
          position_next  = pos_inc;
          countdown_next = dur;
        end
        PH_OFF: begin
          if (cur_byte < END_MARK) begin
            drive_next     = 1'b1;
            position_next  = pos_inc;
            countdown_next = dur;
          end else if ((cur_byte != END_MARK) && repeat_ok) begin
            position_next     = '0;
            repeats_done_next = repeats_done + REP_W'(1);
          end
        end
        PH_STOP: drive_next = 1'b0;
        default: drive_next = drive;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      position     <= '0;
      repeats_done <= '0;
      countdown    <= '0;
      drive        <= 1'b0;
    end else begin
      phase        <= phase_next;
      position     <= position_next;
      repeats_done <= repeats_done_next;
      countdown    <= countdown_next;
      drive        <= drive_next;
    end
  end

  assign rd_addr      = position_next;
  assign status.drive = drive;
  assign status.phase = phase;

endmodule
`default_nettype wire

// File: rtl/core/buzzer_pattern_sequencer_unit.sv
`default_nettype none
// Buzzer pattern player. Every input transaction (tick, pattern load, start or
// stop) is taken while no output waits, and the transaction that follows it can
// be taken in the next cycle; the only limit is the single register stage that
// holds the player state and the pattern byte at the current position, which
// is read from the pattern memory using the next position. Each input transaction
// gives exactly one output transaction carrying the buzzer level and phase
// after that input. A new input is held off only while the output transaction
// waits. Pattern bytes have no reset and must be loaded before a pattern plays.
module buzzer_pattern_sequencer_unit
  import bps_pkg::*;
#(
  parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            operation,
  input  wire logic [IDX_W-1:0]      entry_index,
  input  wire logic [BYTE_W-1:0]     entry_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       buzzer_on,
  output logic                       active,
  output logic      [2:0]            phase,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int PW = $clog2(PATTERN_DEPTH);

  logic              accept;
  item_t             item;
  status_t           status;
  logic [PW-1:0]     rd_addr;
  logic [BYTE_W-1:0] cur_byte;
  logic [TPU_W-1:0]  ticks_per_unit;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign item.op    = op_t'(operation);
  assign item.index = entry_index;
  assign item.value = entry_value;

  bps_cfg_regs u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .ticks_per_unit (ticks_per_unit)
  );

  bps_pattern_store #(
    .PATTERN_DEPTH (PATTERN_DEPTH)
  ) u_store (
    .clk      (clk),
    .wr_en    (accept && (item.op == OP_LOAD)),
    .wr_index (item.index),
    .wr_data  (item.value),
    .rd_addr  (rd_addr),
    .rd_byte  (cur_byte)
  );

  bps_phase_ctrl #(
    .PATTERN_DEPTH (PATTERN_DEPTH)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .item           (item),
    .cur_byte       (cur_byte),
    .ticks_per_unit (ticks_per_unit),
    .rd_addr        (rd_addr),
    .status         (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign buzzer_on = status.drive;
  assign phase     = status.phase;
  assign active    = status.phase != PH_IDLE;

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_start_enters_start: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.op == OP_START)) |=> (status.phase == PH_START))
    else $error("start did not enter the start phase");

  a_stop_enters_stop: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.op == OP_STOP) && (status.phase != PH_IDLE))
      |=> (status.phase == PH_STOP))
    else $error("stop while playing did not enter the stop phase");

  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    (status.phase == PH_IDLE) |-> !status.drive)
    else $error("buzzer driven while idle");

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bps_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic       buzzer;
    logic       act;
    logic [2:0] ph;
  } player_status_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            operation = '0;
  logic [IDX_W-1:0]      entry_index = '0;
  logic [BYTE_W-1:0]     entry_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  buzzer_on;
  logic                  active;
  logic [2:0]            phase;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  buzzer_pattern_sequencer_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .buzzer_on   (buzzer_on),
    .active      (active),
    .phase       (phase),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Player state as predicted from the accepted input transactions.
  logic [BYTE_W-1:0]  pat_mem [IDX_COUNT];
  logic [IDX_W-1:0]   play_pos = '0;
  logic [REP_W-1:0]   rep_count = '0;
  phase_t             play_phase = PH_IDLE;
  logic [COUNT_W-1:0] tick_count = '0;
  logic               drive_lvl = 1'b0;
  logic [TPU_W-1:0]   unit_ticks = TPU_RESET;

  item_t          pending_items[$];
  item_t          next_item;
  player_status_t expected_status[$];
  player_status_t want;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             error_count = 0;
  int             queued_count = 0;
  int             hold_trigger = 0;
  int             hold_seen = 0;
  int             hold_left = 0;
  int             quiet_cycles = 0;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", field, got, exp_val, $time);
    error_count++;
  endtask

  function automatic int seg_ticks(input logic [BYTE_W-1:0] b);
    int d;
    d = int'(b) * int'(unit_ticks);
    return (d == 0) ? 1 : d;
  endfunction

  function automatic logic [COUNT_W-1:0] player_step();
    logic [BYTE_W-1:0] b;
    b = pat_mem[play_pos];
    case (play_phase)
      PH_START: begin
        drive_lvl = 1'b1;
        play_pos = play_pos + 1'b1;
        play_phase = PH_ON;
        return COUNT_W'(seg_ticks(b));
      end
      PH_ON: begin
        drive_lvl = 1'b0;
        play_pos = play_pos + 1'b1;
        play_phase = PH_OFF;
        return COUNT_W'(seg_ticks(b));
      end
      PH_OFF: begin
        if (b < END_MARK) begin
          drive_lvl = 1'b1;
          play_pos = play_pos + 1'b1;
          play_phase = PH_ON;
          return COUNT_W'(seg_ticks(b));
        end
        if (b == END_MARK) begin
          play_phase = PH_STOP;
        end else if ({4'd0, rep_count} < (b - END_MARK)) begin
          play_pos = '0;
          rep_count = rep_count + 1'b1;
          play_phase = PH_START;
        end else begin
          play_phase = PH_STOP;
        end
        return COUNT_W'(1);
      end
      PH_STOP: begin
        drive_lvl = 1'b0;
        play_phase = PH_IDLE;
        return COUNT_W'(1);
      end
      default: begin
        play_phase = PH_IDLE;
        return COUNT_W'(1);
      end
    endcase
  endfunction

  function automatic player_status_t apply_item(input op_t op, input logic [IDX_W-1:0] idx,
                                                input logic [BYTE_W-1:0] val);
    player_status_t st;
    case (op)
      OP_TICK: begin
        if (play_phase != PH_IDLE) begin
          if (tick_count > COUNT_W'(1)) tick_count = tick_count - 1'b1;
          else tick_count = player_step();
        end
      end
      OP_LOAD: pat_mem[idx] = val;
      OP_START: begin
        play_pos = '0;
        rep_count = '0;
        play_phase = PH_START;
      end
      default: begin
        if (play_phase != PH_IDLE) play_phase = PH_STOP;
      end
    endcase
    st.buzzer = drive_lvl;
    st.act = (play_phase != PH_IDLE);
    st.ph = play_phase;
    return st;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_status.push_back(apply_item(op_t'(operation), entry_index, entry_value));
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          in_valid <= 1'b1;
          operation <= next_item.op;
          entry_index <= next_item.index;
          entry_value <= next_item.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        report_mismatch("unexpected output transaction", {29'd0, phase}, 32'd0);
      end else begin
        want = expected_status.pop_front();
        if (buzzer_on !== want.buzzer) report_mismatch("buzzer_on", buzzer_on, want.buzzer);
        if (active !== want.act) report_mismatch("active", active, want.act);
        if (phase !== want.ph) report_mismatch("phase", phase, want.ph);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_item(input op_t op, input logic [IDX_W-1:0] idx,
                                     input logic [BYTE_W-1:0] val);
    item_t it;
    it.op = op;
    it.index = idx;
    it.value = val;
    pending_items.push_back(it);
    queued_count++;
  endfunction

  function automatic void rand_item(input op_t op);
    queue_item(op, IDX_W'($urandom), BYTE_W'($urandom));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_duration(input bit allow_marker);
    if (allow_marker && unit_ticks == 1 && $urandom_range(0, 11) == 0)
      return BYTE_W'($urandom_range(8'hF0, 8'hFF));
    if (unit_ticks >= 50) return ($urandom_range(0, 7) == 0) ? 8'd1 : 8'd0;
    if (unit_ticks > 4) return BYTE_W'($urandom_range(0, 2));
    return BYTE_W'($urandom_range(0, 5));
  endfunction

  // Durations sit at position 0 and at odd positions; even positions from 2 on
  // are read in the off step, where a marker byte ends or repeats the pattern.
  task automatic add_pattern_run();
    int pairs;
    int last;
    int total;
    int reps;
    int est;
    int nticks;
    int r;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] term;
    pairs = $urandom_range(0, 3);
    last = 2 + 2 * pairs;
    total = 0;
    for (int p = 0; p < last; p++) begin
      b = pick_duration(p == 0 || p % 2 == 1);
      queue_item(OP_LOAD, IDX_W'(p), b);
      total += seg_ticks(b);
    end
    r = $urandom_range(0, 9);
    if (r < 5) term = END_MARK;
    else if (unit_ticks <= 2 && r == 9) term = BYTE_W'($urandom_range(8'hF4, 8'hFF));
    else if (unit_ticks <= 10) term = END_MARK + BYTE_W'($urandom_range(1, 3));
    else term = END_MARK + 1'b1;
    queue_item(OP_LOAD, IDX_W'(last), term);
    reps = int'(term - END_MARK);
    est = (total + last + 3) * (reps + 1);
    if (est > 400) nticks = $urandom_range(100, 400);
    else nticks = $urandom_range(est / 2, est + est / 4 + 2);
    rand_item(OP_START);
    for (int t = 0; t < nticks; t++) begin
      r = $urandom_range(0, 59);
      if (r == 0) rand_item(OP_STOP);
      else if (r == 1) rand_item(OP_START);
      else if (r == 2) queue_item(OP_LOAD, IDX_W'($urandom), BYTE_W'($urandom));
      else rand_item(OP_TICK);
    end
  endtask

  task automatic add_random(input int count);
    int first;
    int n;
    first = queued_count;
    while (queued_count - first < count) begin
      if ($urandom_range(0, 99) < 80) begin
        add_pattern_run();
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) rand_item(op_t'($urandom_range(0, 3)));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_status.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_unit_ticks(input int value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(4 * REG_TPU);
    pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    unit_ticks = TPU_W'(value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    check_unit_ticks();
  endtask

  task automatic check_unit_ticks();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= CFG_ADDR_W'(4 * REG_TPU);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[TPU_W-1:0] !== unit_ticks)
      report_mismatch("ticks_per_unit readback", prdata, unit_ticks);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    check_unit_ticks();

    // Idle tick and stop, then a zero-length pattern, a single repeat, and a
    // stop that waits for the running countdown.
    rand_item(OP_TICK);
    rand_item(OP_STOP);
    queue_item(OP_LOAD, 6'd0, 8'd0);
    queue_item(OP_LOAD, 6'd1, 8'd0);
    queue_item(OP_LOAD, 6'd2, END_MARK);
    rand_item(OP_START);
    repeat (4) rand_item(OP_TICK);
    queue_item(OP_LOAD, 6'd2, END_MARK + 1'b1);
    queue_item(OP_LOAD, 6'd63, 8'hFF);
    rand_item(OP_START);
    repeat (7) rand_item(OP_TICK);
    queue_item(OP_LOAD, 6'd1, 8'd1);
    rand_item(OP_START);
    repeat (2) rand_item(OP_TICK);
    rand_item(OP_STOP);
    rand_item(OP_TICK);
    wait_drained();

    // Fill the whole store with short durations and play past the wrap.
    set_unit_ticks(1);
    for (int i = 0; i < IDX_COUNT; i++) queue_item(OP_LOAD, IDX_W'(i), BYTE_W'($urandom_range(0, 2)));
    rand_item(OP_START);
    repeat (160) rand_item(OP_TICK);
    rand_item(OP_STOP);
    add_random(150);
    wait_drained();

    set_unit_ticks(2);
    send_idle_pct = 64;
    add_random(120);
    wait_drained();

    set_unit_ticks(100);
    send_idle_pct = 0;
    recv_stall_pct = 64;
    add_random(100);
    wait_drained();

    set_unit_ticks($urandom_range(3, 99));
    send_idle_pct = 28;
    recv_stall_pct = 28;
    add_random(130);
    wait_drained();

    set_unit_ticks(7);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_random(130);
    @(posedge clk);
    hold_trigger <= hold_trigger + 1;
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_status.size() != 0)
      report_mismatch("output transactions missing", expected_status.size(), 0);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
